// File: sv/alr_pkg.sv
`timescale 1ns / 1ps
package alr_pkg;

  localparam int unsigned DEFAULT_TABLE_DEPTH = 16;

  localparam int unsigned OFF_W   = 5;
  localparam int unsigned MASK_W  = 2 ** OFF_W;
  localparam int unsigned DEV_W   = 16;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned ADDR_W  = 32;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_POOL_START    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POOL_SIZE     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LEASE_TIMEOUT = 2'd2;

  localparam logic [OFF_W-1:0]  RST_POOL_SIZE     = 5'd16;
  localparam logic [TIME_W-1:0] RST_LEASE_TIMEOUT = 32'd1000;

  typedef enum logic [1:0] {
    CMD_TICK    = 2'd0,
    CMD_REQUEST = 2'd1,
    CMD_RENEW   = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_LOOK = 2'd1,
    ST_DONE = 2'd2
  } state_e;

  typedef struct packed {
    logic [1:0]        command;
    logic [DEV_W-1:0]  device_id;
    logic [TIME_W-1:0] time_now;
  } req_t;

  typedef struct packed {
    logic [DEV_W-1:0]  client_id;
    logic [ADDR_W-1:0] offered_addr;
  } rsp_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic              tick_en;
    logic              renew_en;
    logic [DEV_W-1:0]  device;
    logic [TIME_W-1:0] cur_time;
    logic [TIME_W-1:0] tick_time;
    logic [TIME_W-1:0] timeout;
    logic [OFF_W-1:0]  new_offset;
  } cell_ctrl_t;

endpackage

// File: sv/alr_cell.sv
`timescale 1ns / 1ps
module alr_cell (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  alr_pkg::cell_ctrl_t            ctrl_i,
  input  logic                           write_i,
  input  logic                           claimed_i,
  input  logic [alr_pkg::MASK_W-1:0]     taken_i,
  input  logic [alr_pkg::OFF_W-1:0]      hit_off_i,
  output logic                           claimed_o,
  output logic [alr_pkg::MASK_W-1:0]     taken_o,
  output logic [alr_pkg::OFF_W-1:0]      hit_off_o,
  output logic                           hit_o,
  output logic                           free_sel_o
);
  import alr_pkg::*;

  logic              valid_q, valid_d;
  logic [OFF_W-1:0]  offset_q;
  logic [DEV_W-1:0]  device_q;
  logic [TIME_W-1:0] renewed_q;
  logic [TIME_W-1:0] age;
  logic              expired;

  // match and expiry for this entry
  assign hit_o   = valid_q && (device_q == ctrl_i.device);
  assign age     = ctrl_i.tick_time - renewed_q;
  assign expired = valid_q && (age > ctrl_i.timeout);

  // pass the chain on to the next cell
  assign free_sel_o = !valid_q && !claimed_i;
  assign claimed_o  = claimed_i || !valid_q;
  assign taken_o    = taken_i | (valid_q ? (MASK_W'(1) << offset_q) : '0);
  assign hit_off_o  = hit_off_i | (hit_o ? offset_q : '0);

  always_comb begin
    valid_d = valid_q;
    if (write_i) begin
      valid_d = 1'b1;
    end else if (ctrl_i.tick_en && expired) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // store a new lease or refresh the renewal time
  always_ff @(posedge clk_i) begin
    if (write_i) begin
      offset_q  <= ctrl_i.new_offset;
      device_q  <= ctrl_i.device;
      renewed_q <= ctrl_i.cur_time;
    end else if (ctrl_i.renew_en && hit_o) begin
      renewed_q <= ctrl_i.cur_time;
    end
  end

endmodule

// File: sv/address_lease_allocator.sv
`timescale 1ns / 1ps
// Lease table for an address pool.
// Input: start / busy command channel carrying req_i (command, device_id,
// time_now). A transaction is taken at a clock edge with start high and busy
// low. Tick and renew commands finish in ST_LOOK; a request goes on through
// ST_DONE. Busy stays high until the state is back in ST_IDLE, and no new
// transaction is taken before then.
// Output: result_strobe_o marks rsp_o for exactly one cycle; both are registered
// from ST_DONE. Only a request produces an offer; a full pool or full table
// yields none for a new device. The receiver cannot stall the output.
// The table is a row of TABLE_DEPTH cells. Lookups ripple along the row
// (first free slot, taken offsets, matching device) combinationally; the lowest
// free offset is picked from the registered taken mask in the next cycle.
// Configuration: cfg_valid_i / cfg_ready_o with cfg_index_i and cfg_data_i,
// always ready; write only while idle.
// Reset clears the table, sets current time to zero and loads the default
// pool size and lease timeout; no clearing pass is needed.
module address_lease_allocator #(
  parameter int unsigned TABLE_DEPTH = alr_pkg::DEFAULT_TABLE_DEPTH
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  output logic                             busy,
  input  alr_pkg::req_t                    req_i,
  output logic                             result_strobe_o,
  output alr_pkg::rsp_t                    rsp_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [alr_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [alr_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import alr_pkg::*;

  state_e            state_q, state_d;
  logic [1:0]        cmd_q;
  logic [DEV_W-1:0]  dev_q;
  logic [TIME_W-1:0] tnow_q;
  logic [TIME_W-1:0] cur_time_q;
  logic [ADDR_W-1:0] pool_start_q;
  logic [OFF_W-1:0]  pool_size_q;
  logic [TIME_W-1:0] timeout_q;

  logic                   hit_q;
  logic [OFF_W-1:0]       hit_off_q;
  logic [TABLE_DEPTH-1:0] free_sel_q;
  logic [MASK_W-1:0]      taken_q;

  logic              strobe_q;
  rsp_t              rsp_q;

  cell_ctrl_t             ctrl;
  logic [TABLE_DEPTH-1:0] write_en;
  logic [TABLE_DEPTH-1:0] hit_vec;
  logic [TABLE_DEPTH-1:0] free_sel;
  logic [TABLE_DEPTH:0]   claimed_chain;
  logic [MASK_W-1:0]      taken_chain   [TABLE_DEPTH+1];
  logic [OFF_W-1:0]       hit_off_chain [TABLE_DEPTH+1];

  logic              look;
  logic              alloc;
  logic              off_found;
  logic [OFF_W-1:0]  free_off;
  logic              accept;

  assign accept      = start && !busy;
  assign busy        = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign look        = (state_q == ST_LOOK);

  // broadcast control to the row
  always_comb begin
    ctrl.tick_en    = look && (cmd_q == CMD_TICK);
    ctrl.renew_en   = look && (cmd_q == CMD_RENEW);
    ctrl.device     = dev_q;
    ctrl.cur_time   = cur_time_q;
    ctrl.tick_time  = tnow_q;
    ctrl.timeout    = timeout_q;
    ctrl.new_offset = free_off;
  end

  assign claimed_chain[0] = 1'b0;
  assign taken_chain[0]   = '0;
  assign hit_off_chain[0] = '0;

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    alr_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .write_i    (write_en[g]),
      .claimed_i  (claimed_chain[g]),
      .taken_i    (taken_chain[g]),
      .hit_off_i  (hit_off_chain[g]),
      .claimed_o  (claimed_chain[g+1]),
      .taken_o    (taken_chain[g+1]),
      .hit_off_o  (hit_off_chain[g+1]),
      .hit_o      (hit_vec[g]),
      .free_sel_o (free_sel[g])
    );
  end

  // pick the lowest offset in 1..pool_size not held by a valid entry
  always_comb begin
    free_off  = '0;
    off_found = 1'b0;
    for (int k = MASK_W - 1; k >= 1; k--) begin
      if (!taken_q[k] && (OFF_W'(k) <= pool_size_q)) begin
        free_off  = OFF_W'(k);
        off_found = 1'b1;
      end
    end
  end

  assign alloc    = (state_q == ST_DONE) && !hit_q && (|free_sel_q) && off_found;
  assign write_en = alloc ? free_sel_q : '0;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) state_d = ST_LOOK;
      end
      ST_LOOK: begin
        state_d = (cmd_q == CMD_REQUEST) ? ST_DONE : ST_IDLE;
      end
      ST_DONE: begin
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // capture the command transaction
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q  <= req_i.command;
      dev_q  <= req_i.device_id;
      tnow_q <= req_i.time_now;
    end
  end

  // hold the lookup results for the allocation cycle
  always_ff @(posedge clk_i) begin
    if (look) begin
      hit_q      <= |hit_vec;
      hit_off_q  <= hit_off_chain[TABLE_DEPTH];
      free_sel_q <= free_sel;
      taken_q    <= taken_chain[TABLE_DEPTH];
    end
  end

  // current time and configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_time_q   <= '0;
      pool_start_q <= '0;
      pool_size_q  <= RST_POOL_SIZE;
      timeout_q    <= RST_LEASE_TIMEOUT;
    end else begin
      if (ctrl.tick_en) begin
        cur_time_q <= tnow_q;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          CFG_POOL_START:    pool_start_q <= cfg_data_i;
          CFG_POOL_SIZE:     pool_size_q  <= cfg_data_i[OFF_W-1:0];
          CFG_LEASE_TIMEOUT: timeout_q    <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // drive the offer strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strobe_q <= 1'b0;
    end else begin
      strobe_q <= (state_q == ST_DONE) && (hit_q || alloc);
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_DONE) begin
      rsp_q.client_id    <= dev_q;
      rsp_q.offered_addr <= pool_start_q +
                            {{(ADDR_W-OFF_W){1'b0}}, (hit_q ? hit_off_q : free_off)};
    end
  end

  assign result_strobe_o = strobe_q;
  assign rsp_o           = rsp_q;

endmodule

// File: sv/alr_checker.sv
`timescale 1ns / 1ps
module alr_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  input  logic                           busy,
  input  alr_pkg::req_t                  req_i,
  input  logic                           result_strobe_o
);
  import alr_pkg::*;

  // an accepted transaction makes the block busy
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("busy not raised after accepted transaction");

  // offers come singly
  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o |=> !result_strobe_o)
    else $error("result strobe held for more than one cycle");

  // an offer answers an earlier accepted request
  a_strobe_from_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o |-> ($past(start && !busy, 3) &&
                         ($past(req_i.command, 3) == CMD_REQUEST)))
    else $error("result strobe without a matching request");

  // the block is free again when an offer appears
  a_idle_on_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o |-> !busy)
    else $error("block still busy while presenting an offer");

endmodule

bind address_lease_allocator alr_checker u_alr_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .start           (start),
  .busy            (busy),
  .req_i           (req_i),
  .result_strobe_o (result_strobe_o)
);
